>>> rtl/core/modulo_hash_set_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modulo hash set engine
// Shared concurrent assertion forms, sampled on the rising clock edge and
// held off while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MODULO_HASH_SET_ENGINE_UNIT_MACROS_SVH
`define MODULO_HASH_SET_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define MHSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define MHSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mhse_pkg.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine package
// Widths, codes, state types and the queue entry shared by every module but the generic RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhse_pkg;

  // Field widths.
  localparam int KEY_W    = 31;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Table geometry.
  localparam int NUM_BUCKETS      = 13;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int SLOT_AW          = $clog2(TOTAL_SLOTS);
  localparam int BUCKET_W         = $clog2(NUM_BUCKETS);
  localparam int SLOT_IW          = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SCAN_CNT_W       = $clog2(SLOTS_PER_BUCKET + 1);

  // Bucket reduction works on the key a digit at a time, most significant first.
  localparam int DIGIT_BITS  = 4;
  localparam int NUM_DIGITS  = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int KEY_PAD_W   = NUM_DIGITS * DIGIT_BITS;
  localparam int DIGIT_CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // Request queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [ACTION_W-1:0] action_code_t;
  typedef logic [STATUS_W-1:0] status_code_t;
  typedef logic [SLOT_AW-1:0]  slot_addr_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_COMMIT
  } back_state_t;

  // A classified request: what to do, on which key, in which bucket.
  typedef struct packed {
    action_code_t action;
    key_t         key;
    slot_addr_t   base;
  } req_entry_t;

endpackage

>>> rtl/core/mhse_if.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine channel interfaces
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mhse_req_if;
  import mhse_pkg::*;

  logic         valid;
  logic         ready;
  action_code_t action;
  key_t         key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

interface mhse_rsp_if;
  import mhse_pkg::*;

  logic         valid;
  logic         ready;
  logic         present;
  status_code_t status;

  modport source (output valid, output present, output status, input ready);
  modport sink (input valid, input present, input status, output ready);
endinterface

>>> rtl/core/mhse_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mhse_front.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine front end
// Accepts a request and reduces its key to a bucket base address, one digit
// per cycle, then pushes the classified request into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhse_front (
  input  logic                clk,
  input  logic                rst_n,
  mhse_req_if.sink            in_req,
  output logic                push_valid,
  output mhse_pkg::req_entry_t push_entry,
  input  logic                q_full
);
  import mhse_pkg::*;

  front_state_t           state_r, state_nxt;
  logic [KEY_PAD_W-1:0]   digits_r, digits_nxt;
  logic [BUCKET_W-1:0]    rem_r, rem_nxt;
  logic [DIGIT_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  action_code_t           action_r, action_nxt;
  key_t                   key_r, key_nxt;
  logic                   accept;

  // Folds one digit into a remainder that is already below the bucket count.
  // Each bit step doubles, adds the bit and subtracts the modulus at most once.
  function automatic logic [BUCKET_W-1:0] mod_digit(input logic [BUCKET_W-1:0]   r,
                                                     input logic [DIGIT_BITS-1:0] digit);
    logic [BUCKET_W:0]   t;
    logic [BUCKET_W-1:0] acc;
    acc = r;
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      t = {acc, digit[i]};
      if (t >= (BUCKET_W + 1)'(NUM_BUCKETS)) begin
        t = t - (BUCKET_W + 1)'(NUM_BUCKETS);
      end
      acc = t[BUCKET_W-1:0];
    end
    return acc;
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE: begin
        if (in_req.valid) begin
          state_nxt = FR_DIV;
        end
      end
      FR_DIV: begin
        if (dig_cnt_r == '0) begin
          state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_req.ready = 1'b0;
    push_valid   = 1'b0;
    unique case (state_r)
      FR_IDLE: in_req.ready = 1'b1;
      FR_PUSH: push_valid   = 1'b1;
      default: ;
    endcase
  end

  assign accept = in_req.valid && in_req.ready;

  // Datapath.
  always_comb begin
    digits_nxt  = digits_r;
    rem_nxt     = rem_r;
    dig_cnt_nxt = dig_cnt_r;
    action_nxt  = action_r;
    key_nxt     = key_r;
    if (accept) begin
      digits_nxt  = KEY_PAD_W'(in_req.key);
      rem_nxt     = '0;
      dig_cnt_nxt = DIGIT_CNT_W'(NUM_DIGITS - 1);
      action_nxt  = in_req.action;
      key_nxt     = in_req.key;
    end else if (state_r == FR_DIV) begin
      rem_nxt     = mod_digit(rem_r, digits_r[KEY_PAD_W-1 -: DIGIT_BITS]);
      digits_nxt  = digits_r << DIGIT_BITS;
      dig_cnt_nxt = dig_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r  <= digits_nxt;
    rem_r     <= rem_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    action_r  <= action_nxt;
    key_r     <= key_nxt;
  end

  assign push_entry.action = action_r;
  assign push_entry.key    = key_r;
  assign push_entry.base   = SLOT_AW'(32'(rem_r) * SLOTS_PER_BUCKET);

endmodule

>>> rtl/core/mhse_queue.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine request queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhse_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mhse_pkg::req_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output mhse_pkg::req_entry_t pop_entry,
  output logic                 empty
);
  import mhse_pkg::*;

  req_entry_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = slots_r[rd_ptr_r];

endmodule

>>> rtl/core/mhse_back.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine back end
// Scans the slots of one bucket through the key RAM, then inserts, removes
// or reports, and loads the result into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modulo_hash_set_engine_unit_macros.svh"

module mhse_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mhse_pkg::req_entry_t q_entry,
  output logic                 q_pop,
  mhse_rsp_if.source           out_rsp
);
  import mhse_pkg::*;

  back_state_t           state_r, state_nxt;
  req_entry_t            cur_r, cur_nxt;
  logic [SCAN_CNT_W-1:0] issue_cnt_r, issue_cnt_nxt;
  logic                  cmp_vld_r;
  logic [SLOT_IW-1:0]    cmp_idx_r;
  logic                  hit_r, hit_nxt;
  logic [SLOT_IW-1:0]    hit_idx_r, hit_idx_nxt;
  logic                  free_r, free_nxt;
  logic [SLOT_IW-1:0]    free_idx_r, free_idx_nxt;
  logic                  used_r, used_nxt;
  logic [TOTAL_SLOTS-1:0] valid_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_present_r;
  status_code_t          out_status_r;

  logic                  issue;
  slot_addr_t            rd_addr;
  slot_addr_t            cmp_addr;
  key_t                  ram_rdata;
  logic                  slot_valid;
  logic                  slot_match;
  logic                  scan_last;
  logic                  commit_go;
  logic                  ram_we;
  logic                  rem_clear;
  slot_addr_t            ins_addr;
  slot_addr_t            clr_addr;
  status_t               status_res;

  assign issue     = (state_r == BK_SCAN) && (issue_cnt_r < SCAN_CNT_W'(SLOTS_PER_BUCKET));
  assign rd_addr   = cur_r.base + SLOT_AW'(issue_cnt_r[SLOT_IW-1:0]);
  assign cmp_addr  = cur_r.base + SLOT_AW'(cmp_idx_r);
  assign slot_valid = valid_r[cmp_addr];
  assign slot_match = slot_valid && (ram_rdata == cur_r.key);
  assign scan_last = cmp_vld_r && (cmp_idx_r == SLOT_IW'(SLOTS_PER_BUCKET - 1));
  assign commit_go = (state_r == BK_COMMIT) && (!out_valid_r || out_rsp.ready);
  assign ins_addr  = cur_r.base + SLOT_AW'(free_idx_r);
  assign clr_addr  = cur_r.base + SLOT_AW'(hit_idx_r);
  assign ram_we    = commit_go && (cur_r.action == ACT_INSERT) && !hit_r && free_r;
  assign rem_clear = commit_go && (cur_r.action == ACT_REMOVE) && used_r && hit_r;

  mhse_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TOTAL_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_addr),
    .wdata (cur_r.key),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_last) begin
          state_nxt = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        if (commit_go) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Queue handshake.
  always_comb begin
    q_pop = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = !q_empty;
      default: ;
    endcase
  end

  // Result decode from the scan summary.
  always_comb begin
    status_res = ST_OK;
    unique case (cur_r.action)
      ACT_INSERT: begin
        if (!hit_r && !free_r) begin
          status_res = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (!used_r) begin
          status_res = ST_EMPTY;
        end else if (!hit_r) begin
          status_res = ST_NOT_FOUND;
        end
      end
      default: status_res = ST_OK;
    endcase
  end

  // Scan bookkeeping.
  always_comb begin
    cur_nxt       = cur_r;
    issue_cnt_nxt = issue_cnt_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    used_nxt      = used_r;
    if (q_pop) begin
      cur_nxt       = q_entry;
      issue_cnt_nxt = '0;
      hit_nxt       = 1'b0;
      free_nxt      = 1'b0;
      used_nxt      = 1'b0;
    end else begin
      if (issue) begin
        issue_cnt_nxt = issue_cnt_r + 1'b1;
      end
      if (cmp_vld_r) begin
        if (slot_valid) begin
          used_nxt = 1'b1;
          if (!hit_r && slot_match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
          end
        end else if (!free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= issue;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[ins_addr] <= 1'b1;
      end else if (rem_clear) begin
        valid_r[clr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    cmp_idx_r   <= issue_cnt_r[SLOT_IW-1:0];
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    used_r      <= used_nxt;
    if (commit_go) begin
      out_present_r <= hit_r;
      out_status_r  <= status_res;
    end
  end

  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.present = out_present_r;
  assign out_rsp.status  = out_status_r;

  `MHSE_ASSERT_IMPLY(a_write_only_on_insert, clk, rst_n, ram_we, (state_r == BK_COMMIT) && (cur_r.action == ACT_INSERT), "key RAM written outside an insert commit")
  `MHSE_ASSERT_IMPLY(a_compare_in_scan, clk, rst_n, cmp_vld_r, state_r == BK_SCAN, "slot compare outside the bucket scan")
  `MHSE_ASSERT_NEXT(a_commit_loads_result, clk, rst_n, commit_go, out_valid_r && (state_r == BK_IDLE), "commit did not load the result register")
  `MHSE_ASSERT_IMPLY(a_pop_only_when_quiet, clk, rst_n, q_pop, (state_r == BK_IDLE) && !cmp_vld_r, "queue popped while a scan is in flight")

endmodule

>>> rtl/core/modulo_hash_set_engine_unit.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine
// A set of 31-bit keys held in bounded hash buckets (bucket = key mod 13),
// supporting insert, lookup and remove, one result per request.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake     Payload
//   in_req    in    valid/ready   action (2 bits), key (31 bits)
//   out_rsp   out   valid/ready   present (1 bit), status (2 bits)
//
// Flow: the front end reduces a key to its bucket one 4-bit digit per
// cycle. The back end scans a bucket one slot at a time, bound by the single
// read port of the key RAM, and takes the next request from the queue only
// once the previous one has committed.
// Reset: rst_n is synchronous and active low; it clears every slot valid bit
// at once, so the table is empty with no clearing pass. Key RAM contents are
// not reset.
// Stalls: a two-entry queue separates the front and back ends, and the result
// register lets the back end scan the next bucket while the previous result
// waits; out_rsp.ready low only stalls the back end at its commit step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modulo_hash_set_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  mhse_req_if.sink   in_req,
  mhse_rsp_if.source out_rsp
);
  import mhse_pkg::*;

  // Classified requests flowing from the front end into the queue.
  logic       push_valid;
  req_entry_t push_entry;
  logic       q_full;

  // Queue head as seen by the back end.
  logic       q_pop;
  req_entry_t q_entry;
  logic       q_empty;

  // The front end takes a transaction, folds the key down to a bucket number
  // digit by digit, and turns that into the bucket's first slot address.
  mhse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  // The queue lets the front end reduce the next key while the back end is
  // still scanning the previous bucket.
  mhse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .empty      (q_empty)
  );

  // The back end walks the bucket slot by slot, noting the first match, the
  // first free slot and whether any slot is in use. It then applies the
  // insert or remove at its commit step and registers the response.
  mhse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_rsp (out_rsp)
  );

endmodule

>>> sim/mhse_set_checker.sv
// ----------------------------------------------------------------------------
// Hash set response checker
// Watches the request and response channels, keeps its own copy of the
// bucketed key table, and compares every response with the answer it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhse_set_checker
  import mhse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  input  logic         req_ready,
  input  action_code_t req_action,
  input  key_t         req_key,
  input  logic         rsp_valid,
  input  logic         rsp_ready,
  input  logic         rsp_present,
  input  status_code_t rsp_status,
  output int           fail_count,
  output int           outstanding
);

  typedef struct {
    logic    present;
    status_t status;
  } set_answer_t;

  key_t        table_key   [TOTAL_SLOTS];
  logic        table_valid [TOTAL_SLOTS];
  set_answer_t pending_answers[$];

  // Scans the bucket of the key, then applies the action to the table copy.
  function automatic set_answer_t apply_set_request(action_code_t act, key_t k);
    int unsigned base;
    int          hit;
    int          free_slot;
    int          used;
    set_answer_t ans;
    base      = (32'(k) % NUM_BUCKETS) * SLOTS_PER_BUCKET;
    hit       = -1;
    free_slot = -1;
    used      = 0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (table_valid[base + s]) begin
        used++;
        if (hit < 0 && table_key[base + s] == k) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    ans.present = (hit >= 0);
    ans.status  = ST_OK;
    if (act == ACT_INSERT) begin
      if (hit < 0) begin
        if (free_slot < 0) begin
          ans.status = ST_FULL;
        end else begin
          table_key[base + free_slot]   = k;
          table_valid[base + free_slot] = 1'b1;
        end
      end
    end else if (act == ACT_REMOVE) begin
      if (used == 0) ans.status = ST_EMPTY;
      else if (hit < 0) ans.status = ST_NOT_FOUND;
      else table_valid[base + hit] = 1'b0;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    set_answer_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) table_valid[i] = 1'b0;
      pending_answers.delete();
    end else begin
      // The response side is handled first so that a response can only ever
      // match a request accepted at an earlier edge.
      if (rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          $error("response transaction with no request outstanding");
          errs++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp_present !== want.present) begin
            $error("present: expected %0d, actual %0d", want.present, rsp_present);
            errs++;
          end
          if (rsp_status !== status_code_t'(want.status)) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_status);
            errs++;
          end
        end
      end
      if (req_valid && req_ready) begin
        pending_answers.push_back(apply_set_request(req_action, req_key));
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= pending_answers.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Modulo hash set engine testbench
// Drives insert, lookup and remove requests into the engine with random
// handshake stalls on both channels; a checker beside the engine predicts
// each response and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mhse_pkg::*;

  // The action code that the engine does not define; it must behave like a
  // lookup.
  localparam action_code_t ACT_SPARE = 2'd3;

  // Largest legal key, and the largest multiplier of the bucket count for
  // which every bucket offset stays within the key range.
  localparam int unsigned KEY_MAX       = 32'h7FFF_FFFF;
  localparam int unsigned HIGH_KEY_BASE = 32'd165191048;

  // Cycles without any accepted transaction before the run is declared hung.
  // This leaves a wide margin over a correct transaction, including the idle
  // bursts on each side.
  localparam int STALL_LIMIT = 2000;

  localparam int RANDOM_ITEMS = 1200;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   quiet_cycles;

  // Percentage chance that either side starts an idle burst; the stimulus
  // changes it from phase to phase and sets it to zero near the end.
  int   idle_pct;

  mhse_req_if req_ch ();
  mhse_rsp_if rsp_ch ();

  modulo_hash_set_engine_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  mhse_set_checker set_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_action  (req_ch.action),
    .req_key     (req_ch.key),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_present (rsp_ch.present),
    .rsp_status  (rsp_ch.status),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Response side backpressure. The ready line is updated once per rising
  // edge; during a stall burst it stays low until the burst counter runs out.
  initial begin : rsp_ready_gen
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 6);
      end
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  // Watchdog: any cycle with an accepted transaction on either channel
  // restarts the count. A lost response therefore ends the run here.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("modulo_hash_set_engine_unit: mismatch");
      $finish;
    end
  end

  // Presents one request and returns at the edge where it is accepted. Ready
  // is looked at on the falling edge, where it is settled, so the handshake
  // never depends on event order at the rising edge. Valid stays high from
  // one request to the next unless an idle burst is inserted in between.
  task automatic send_request(action_code_t act, key_t k);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.key    <= k;
    do @(negedge clk); while (!req_ch.ready);
    @(posedge clk);
  endtask

  // Keys are mostly drawn from a small pool per bucket, so that buckets fill
  // up, keys repeat and removals hit; a few buckets are favored to reach the
  // full case often. A share of keys sits at the top of the key range, and
  // the rest are fully random so that every key bit toggles.
  function automatic key_t pick_key();
    int unsigned bucket;
    int unsigned sel;
    bucket = ($urandom_range(0, 99) < 50) ? $urandom_range(0, 2) : $urandom_range(0, 12);
    sel    = $urandom_range(0, 99);
    if (sel < 70) return key_t'(bucket + NUM_BUCKETS * $urandom_range(0, 10));
    if (sel < 85) return key_t'(NUM_BUCKETS * (HIGH_KEY_BASE - $urandom_range(0, 10)) + bucket);
    return key_t'($urandom());
  endfunction

  function automatic action_code_t pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ACT_INSERT;
    if (r < 65) return ACT_LOOKUP;
    if (r < 95) return ACT_REMOVE;
    return ACT_SPARE;
  endfunction

  initial begin : stimulus
    idle_pct      = 0;
    rst_n         <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_INSERT;
    req_ch.key    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Bucket 0 holds keys 0, 13, 26, ...; the largest key
    // falls in bucket 10.
    idle_pct = 30;
    send_request(ACT_REMOVE, key_t'(0));        // remove from an empty bucket
    send_request(ACT_LOOKUP, key_t'(0));        // lookup of an absent key
    send_request(ACT_INSERT, key_t'(0));        // insert the smallest key
    send_request(ACT_INSERT, key_t'(0));        // insert of a key already held
    send_request(ACT_LOOKUP, key_t'(0));
    send_request(ACT_INSERT, key_t'(KEY_MAX));  // insert the largest key
    send_request(ACT_REMOVE, key_t'(13));       // absent key, non-empty bucket
    for (int i = 1; i < SLOTS_PER_BUCKET; i++) begin
      send_request(ACT_INSERT, key_t'(NUM_BUCKETS * i));
    end
    // Bucket 0 is now full, so this insert is dropped.
    send_request(ACT_INSERT, key_t'(NUM_BUCKETS * SLOTS_PER_BUCKET));
    // Free a slot in the middle; the next insert must land there.
    send_request(ACT_REMOVE, key_t'(NUM_BUCKETS * 3));
    send_request(ACT_INSERT, key_t'(NUM_BUCKETS * SLOTS_PER_BUCKET));
    send_request(ACT_LOOKUP, key_t'(NUM_BUCKETS * SLOTS_PER_BUCKET));
    send_request(ACT_SPARE, key_t'(0));         // undefined action, present key
    send_request(ACT_SPARE, key_t'(5));         // undefined action, absent key
    send_request(ACT_REMOVE, key_t'(KEY_MAX));  // removal of a present key
    send_request(ACT_LOOKUP, key_t'(KEY_MAX));
    send_request(ACT_REMOVE, key_t'(0));

    // Random part. The idle rate changes every hundred requests, including
    // stretches with no idling at all, and the tail runs at full rate.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (n >= RANDOM_ITEMS - 150) idle_pct = 0;
      send_request(pick_action(), pick_key());
    end
    req_ch.valid <= 1'b0;

    // Drain: let the checker record the last request, wait for every
    // predicted response, then allow for one more request's worth of
    // latency before the verdict.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("modulo_hash_set_engine_unit: match");
    end else begin
      $display("modulo_hash_set_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
